>>> rtl/core/ancs_pkg.sv
`default_nettype none
package ancs_pkg;

    localparam logic [1:0] KIND_COORD  = 2'd0;
    localparam logic [1:0] KIND_PHER   = 2'd1;
    localparam logic [1:0] KIND_CHOOSE = 2'd2;

    localparam int CITY_W     = 5;
    localparam int COORD_W    = 15;
    localparam int PHER_W     = 32;
    localparam int MASK_W     = 32;
    localparam int RAND_W     = 16;
    localparam int WEIGHT_W   = 32;
    localparam int CNT_W      = 7;
    localparam int SCAN_W     = 6;
    localparam int SLOT_W     = 14;
    localparam int SQ_W       = 30;
    localparam int DIST_W     = 31;
    localparam int PHM_W      = 39;
    localparam int NUM_W      = 55;
    localparam int TOTAL_W    = 37;
    localparam int THRESH_W   = 53;
    localparam int STEP_W     = 5;

    localparam logic [6:0]          DIST_SCALE = 7'd100;
    localparam logic [SCAN_W-1:0]   CITY_LIMIT = 6'd32;
    localparam logic [STEP_W-1:0]   LAST_STEP  = 5'd31;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'hFFFF_FFFF;
    localparam logic [5:0]          COUNT_RESET = 6'd32;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CUR   = 11'b000_0000_0010,
        S_SCAN  = 11'b000_0000_0100,
        S_MULT  = 11'b000_0000_1000,
        S_SUM   = 11'b000_0001_0000,
        S_START = 11'b000_0010_0000,
        S_DIV   = 11'b000_0100_0000,
        S_RSCAN = 11'b000_1000_0000,
        S_RACC  = 11'b001_0000_0000,
        S_DONE  = 11'b010_0000_0000,
        S_SPARE = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic                done;
        logic [WEIGHT_W-1:0] quot;
    } div_res_t;

    function automatic logic [SLOT_W-1:0] edge_slot(
        input logic [CITY_W-1:0] a,
        input logic [CITY_W-1:0] b,
        input logic [CNT_W-1:0]  n
    );
        logic [SLOT_W-1:0] lo;
        logic [SLOT_W-1:0] hi;
        logic [SLOT_W-1:0] prod;
        lo = (a < b) ? SLOT_W'(a) : SLOT_W'(b);
        hi = (a < b) ? SLOT_W'(b) : SLOT_W'(a);
        prod = (SLOT_W'({n, 1'b0}) - lo - SLOT_W'(1)) * lo;
        return (prod >> 1) + hi - lo - SLOT_W'(1);
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ant_next_city_select.sv
// write items (coordinates, pheromone) are written to the memories while idle
// a decision scans the cities and runs the 32-step serial divider for each
// free candidate to get its weight; roulette then makes a second pass over
// the weight memory
// one item at a time; the result register frees the input side meanwhile
// rst_n clears control state and sets city_count to 32; memories are not cleared
`default_nettype none
module ant_next_city_select
    import ancs_pkg::*;
#(
    parameter int MAX_CITIES = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // city_index, other_city, coord_x, coord_y, pheromone_value, free_mask,
    // explore, random_fraction
    input  wire logic [127:0] s_tdata,
    // kind
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // next_city
    output logic [7:0]        m_tdata,
    // found
    output logic              m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CITY_AW    = $clog2(MAX_CITIES);
    localparam int EDGE_SLOTS = MAX_CITIES * (MAX_CITIES - 1) / 2;
    localparam int PH_AW      = $clog2(EDGE_SLOTS);

    logic [CITY_W-1:0]  in_ci, in_oc;
    logic [COORD_W-1:0] in_x, in_y;
    logic [PHER_W-1:0]  in_ph;
    logic [MASK_W-1:0]  in_mask;
    logic               in_explore;
    logic [RAND_W-1:0]  in_rand;
    logic               in_xfer;

    assign in_ci      = s_tdata[4:0];
    assign in_oc      = s_tdata[9:5];
    assign in_x       = s_tdata[24:10];
    assign in_y       = s_tdata[39:25];
    assign in_ph      = s_tdata[71:40];
    assign in_mask    = s_tdata[103:72];
    assign in_explore = s_tdata[104];
    assign in_rand    = s_tdata[120:105];

    state_t state_reg, state_next;

    logic [5:0]          count_reg;
    logic [CITY_W-1:0]   ci_reg, ci_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic                explore_reg, explore_next;
    logic [RAND_W-1:0]   rand_reg, rand_next;
    logic [SCAN_W-1:0]   cnt_reg, cnt_next;
    logic [COORD_W-1:0]  curx_reg, curx_next, cury_reg, cury_next;
    logic [SQ_W-1:0]     dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic [PHM_W-1:0]    phm_reg, phm_next;
    logic                phz_reg, phz_next;
    logic [DIST_W-1:0]   d2_reg, d2_next;
    logic [TOTAL_W-1:0]  total_reg, total_next, run_reg, run_next;
    logic [WEIGHT_W-1:0] best_reg, best_next;
    logic [CITY_W-1:0]   pick_reg, pick_next, last_reg, last_next;
    logic                any_reg, any_next;
    logic [THRESH_W-1:0] thresh_reg, thresh_next;
    logic                ovalid_reg, ovalid_next;
    logic [CITY_W-1:0]   ocity_reg, ocity_next;
    logic                ofound_reg, ofound_next;

    logic [CNT_W-1:0]    n_eff;
    logic [SCAN_W-1:0]   lim;
    logic                cand;
    logic [SLOT_W-1:0]   wslot, rslot;

    logic                   coord_we;
    logic [CITY_AW-1:0]     coord_raddr;
    logic [2*COORD_W-1:0]   coord_rdata;
    logic                   ph_we;
    logic [PHER_W-1:0]      ph_rdata;
    logic                   w_we;
    logic [WEIGHT_W-1:0]    w_wdata, w_rdata;

    logic                   div_start;
    div_res_t               div_res;

    logic signed [15:0]     dx, dy;
    logic signed [31:0]     dxsq, dysq;
    logic [WEIGHT_W-1:0]    weight;
    logic [TOTAL_W-1:0]     run_sum;

    assign n_eff = ({1'b0, count_reg} < CNT_W'(MAX_CITIES)) ? {1'b0, count_reg}
                                                             : CNT_W'(MAX_CITIES);
    assign lim   = (n_eff > CNT_W'(CITY_LIMIT)) ? CITY_LIMIT : n_eff[SCAN_W-1:0];
    assign cand  = (cnt_reg[CITY_W-1:0] != ci_reg) && mask_reg[cnt_reg[CITY_W-1:0]];
    assign wslot = edge_slot(in_ci, in_oc, n_eff);
    assign rslot = edge_slot(ci_reg, cnt_reg[CITY_W-1:0], n_eff);

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign coord_we = in_xfer && (s_tuser == KIND_COORD)
                   && ({2'b0, in_ci} < CNT_W'(MAX_CITIES));
    assign ph_we    = in_xfer && (s_tuser == KIND_PHER) && (in_ci != in_oc)
                   && ({2'b0, in_ci} < n_eff) && ({2'b0, in_oc} < n_eff)
                   && (wslot < SLOT_W'(EDGE_SLOTS));
    assign coord_raddr = (state_reg == S_IDLE) ? CITY_AW'(in_ci)
                                               : cnt_reg[CITY_AW-1:0];

    ancs_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_CITIES)) u_coord_ram (
        .clk   (clk),
        .we    (coord_we),
        .waddr (CITY_AW'(in_ci)),
        .wdata ({in_x, in_y}),
        .raddr (coord_raddr),
        .rdata (coord_rdata)
    );

    ancs_ram #(.WIDTH(PHER_W), .DEPTH(EDGE_SLOTS)) u_pher_ram (
        .clk   (clk),
        .we    (ph_we),
        .waddr (wslot[PH_AW-1:0]),
        .wdata (in_ph),
        .raddr (rslot[PH_AW-1:0]),
        .rdata (ph_rdata)
    );

    ancs_ram #(.WIDTH(WEIGHT_W), .DEPTH(32)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (cnt_reg[CITY_W-1:0]),
        .wdata (w_wdata),
        .raddr (cnt_reg[CITY_W-1:0]),
        .rdata (w_rdata)
    );

    assign div_start = (state_reg == S_START);

    ancs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({phm_reg, 16'b0}),
        .den   ({1'b0, d2_reg}),
        .res   (div_res)
    );

    assign dx      = $signed({1'b0, coord_rdata[2*COORD_W-1:COORD_W]})
                   - $signed({1'b0, curx_reg});
    assign dy      = $signed({1'b0, coord_rdata[COORD_W-1:0]}) - $signed({1'b0, cury_reg});
    assign dxsq    = dx * dx;
    assign dysq    = dy * dy;
    assign weight  = phz_reg ? '0 : div_res.quot;
    assign run_sum = run_reg + TOTAL_W'(w_rdata);
    assign w_we    = (state_reg == S_DIV) && div_res.done;
    assign w_wdata = weight;

    always_comb
    begin
        state_next   = state_reg;
        ci_next      = ci_reg;
        mask_next    = mask_reg;
        explore_next = explore_reg;
        rand_next    = rand_reg;
        cnt_next     = cnt_reg;
        curx_next    = curx_reg;
        cury_next    = cury_reg;
        dx2_next     = dx2_reg;
        dy2_next     = dy2_reg;
        phm_next     = phm_reg;
        phz_next     = phz_reg;
        d2_next      = d2_reg;
        total_next   = total_reg;
        run_next     = run_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;
        last_next    = last_reg;
        any_next     = any_reg;
        thresh_next  = thresh_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        ocity_next   = ocity_reg;
        ofound_next  = ofound_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (s_tuser == KIND_CHOOSE))
                begin
                    ci_next      = in_ci;
                    mask_next    = in_mask;
                    explore_next = in_explore;
                    rand_next    = in_rand;
                    cnt_next     = '0;
                    total_next   = '0;
                    best_next    = '0;
                    pick_next    = '0;
                    last_next    = '0;
                    any_next     = 1'b0;
                    if ({2'b0, in_ci} >= n_eff)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CUR;
                    end
                end
            end
            S_CUR:
            begin
                curx_next  = coord_rdata[2*COORD_W-1:COORD_W];
                cury_next  = coord_rdata[COORD_W-1:0];
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cnt_reg == lim)
                begin
                    if (any_reg && explore_reg)
                    begin
                        thresh_next = {37'b0, rand_reg} * {16'b0, total_reg};
                        run_next    = '0;
                        cnt_next    = '0;
                        pick_next   = last_reg;
                        state_next  = S_RSCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (cand)
                begin
                    state_next = S_MULT;
                end
                else
                begin
                    cnt_next = cnt_reg + SCAN_W'(1);
                end
            end
            S_MULT:
            begin
                dx2_next   = dxsq[SQ_W-1:0];
                dy2_next   = dysq[SQ_W-1:0];
                phm_next   = {7'b0, ph_rdata} * {32'b0, DIST_SCALE};
                phz_next   = (ph_rdata == '0);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                d2_next    = DIST_W'(dx2_reg) + DIST_W'(dy2_reg);
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    total_next = total_reg + TOTAL_W'(weight);
                    if (!any_reg || (weight > best_reg))
                    begin
                        best_next = weight;
                        pick_next = cnt_reg[CITY_W-1:0];
                    end
                    any_next   = 1'b1;
                    last_next  = cnt_reg[CITY_W-1:0];
                    cnt_next   = cnt_reg + SCAN_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_RSCAN:
            begin
                if (cnt_reg == lim)
                begin
                    state_next = S_DONE;
                end
                else if (cand)
                begin
                    state_next = S_RACC;
                end
                else
                begin
                    cnt_next = cnt_reg + SCAN_W'(1);
                end
            end
            S_RACC:
            begin
                if ({run_sum, 16'b0} > thresh_reg)
                begin
                    pick_next  = cnt_reg[CITY_W-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    run_next   = run_sum;
                    cnt_next   = cnt_reg + SCAN_W'(1);
                    state_next = S_RSCAN;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    ocity_next  = any_reg ? pick_reg : '0;
                    ofound_next = any_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            count_reg  <= COUNT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (psel && penable && pwrite && !paddr[2])
            begin
                count_reg <= pwdata[5:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ci_reg      <= ci_next;
        mask_reg    <= mask_next;
        explore_reg <= explore_next;
        rand_reg    <= rand_next;
        cnt_reg     <= cnt_next;
        curx_reg    <= curx_next;
        cury_reg    <= cury_next;
        dx2_reg     <= dx2_next;
        dy2_reg     <= dy2_next;
        phm_reg     <= phm_next;
        phz_reg     <= phz_next;
        d2_reg      <= d2_next;
        total_reg   <= total_next;
        run_reg     <= run_next;
        best_reg    <= best_next;
        pick_reg    <= pick_next;
        last_reg    <= last_next;
        any_reg     <= any_next;
        thresh_reg  <= thresh_next;
        ocity_reg   <= ocity_next;
        ofound_reg  <= ofound_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {3'b0, ocity_reg};
    assign m_tuser  = ofound_reg;
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'b0 : {26'b0, count_reg};

    a_empty_city_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'b0))
        else $error("no-candidate transfer carries a city");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

    a_run_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RACC) |-> (run_reg <= total_reg))
        else $error("roulette running sum passed the total");

    a_done_waits_output: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && m_tvalid && !m_tready) |=> (state_reg == S_DONE))
        else $error("result overwrote a pending transfer");

endmodule
`default_nettype wire

>>> rtl/core/ancs_ram.sv
`default_nettype none
module ancs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/ancs_div.sv
`default_nettype none
module ancs_div
    import ancs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_W-1:0]    num,
    input  wire logic [WEIGHT_W-1:0] den,
    output div_res_t                 res
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [WEIGHT_W-1:0] rem_reg, rem_next;
    logic [WEIGHT_W-1:0] numl_reg, numl_next;
    logic [WEIGHT_W-1:0] quot_reg, quot_next;
    logic [WEIGHT_W-1:0] den_reg, den_next;
    logic [WEIGHT_W:0]   trial;
    logic [NUM_W-WEIGHT_W-1:0] num_hi;

    assign num_hi = num[NUM_W-1:WEIGHT_W];
    assign trial  = {rem_reg, numl_reg[WEIGHT_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        numl_next = numl_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start)
        begin
            // quotient above 32 bits, or zero divisor, saturates
            if (WEIGHT_W'(num_hi) >= den)
            begin
                quot_next = WEIGHT_MAX;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = WEIGHT_W'(num_hi);
                numl_next = num[WEIGHT_W-1:0];
                den_next  = den;
                step_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = WEIGHT_W'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[WEIGHT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[WEIGHT_W-1:0];
                quot_next = {quot_reg[WEIGHT_W-2:0], 1'b0};
            end
            numl_next = {numl_reg[WEIGHT_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        numl_reg <= numl_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule
`default_nettype wire
